@@ rtl/kscs_pkg.sv @@
// kscs_pkg: sizes, register indexes and shared types for the k-subset cover search.
// No dependencies; every other file of the block refers to it by scoped names.
package kscs_pkg;

   localparam int MAX_ENTRIES = 64;                        // list depth, 2..64
   localparam int COVER_BITS  = 64;                        // stored profile bits, 2..64
   localparam int POS_W       = $clog2(MAX_ENTRIES);       // list position
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);   // entry count, k
   localparam int STACK_DEPTH = MAX_ENTRIES - 1;           // placed slots below the last
   localparam int PROFILE_W   = 64;                        // profile_word / chosen_mask ports
   localparam int REG_W       = 7;                         // config register width
   localparam int CSR_IDX_W   = 2;

   localparam logic [CSR_IDX_W-1:0] REG_SUBSET_SIZE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_COVER_WIDTH = CSR_IDX_W'(1);

   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_SEARCH = 1'b1;

   // one placed slot: its list position and the OR of profiles up to and including it
   typedef struct packed {
      logic [POS_W-1:0]      pos;
      logic [COVER_BITS-1:0] cov;
   } entry_type;

   typedef struct packed {
      logic push;
      logic pop;
   } stack_op_type;

endpackage

@@ rtl/kscs_cell.sv @@
// kscs_cell: one slot of the shifting slot stack.
// Depends on kscs_pkg (entry_type, stack_op_type).
module kscs_cell (
   input  logic                    clock,
   input  kscs_pkg::stack_op_type  op,
   input  kscs_pkg::entry_type     up_entry,
   input  kscs_pkg::entry_type     down_entry,
   output kscs_pkg::entry_type     entry
);

   kscs_pkg::entry_type entry_ff;
   kscs_pkg::entry_type entry_in;

   // push takes the neighbor nearer the top, pop the one further down
   always_comb begin
      entry_in = entry_ff;
      if (op.push) begin
         entry_in = up_entry;
      end else if (op.pop) begin
         entry_in = down_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

@@ rtl/k_subset_cover_search.sv @@
// Timing: a load beat is taken without raising busy. A search with k = 0 answers in the cycle
//   after start; otherwise the walk tries candidate positions (ST_PLACE) and backtracks (ST_BACK,
//   one step per level popped, one more when no cover exists), one step per cycle.
// Throughput: one load per cycle while idle; one search at a time, busy high until its result strobe.
// Reset (synchronous): list emptied, subset_size = 1, cover_width = 64, walk idle. Profile
//   memory and slot stack are not cleared; the result strobe cannot be stalled.
module k_subset_cover_search (
   input  logic                              clock,
   input  logic                              reset,
   // search / load request
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_kind,
   input  logic                              req_start_new,
   input  logic [kscs_pkg::PROFILE_W-1:0]    req_profile_word,
   // result, one-cycle strobe
   output logic                              rsp_strobe,
   output logic                              rsp_found,
   output logic [kscs_pkg::PROFILE_W-1:0]    rsp_chosen_mask,
   // configuration writes
   input  logic                              csr_we,
   input  logic [kscs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [kscs_pkg::REG_W-1:0]        csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PLACE,   // place candidate cand_ff into slot slot_ff
      ST_BACK     // pop the top slot and advance it
   } state_type;

   // ------------------------------------------------------------------
   // Configuration and list length
   // ------------------------------------------------------------------
   logic [kscs_pkg::REG_W-1:0] subset_size_ff, subset_size_in;
   logic [kscs_pkg::REG_W-1:0] cover_width_ff, cover_width_in;
   logic [kscs_pkg::CNT_W-1:0] count_ff, count_in;

   logic load_accept;
   logic search_accept;
   logic list_full;
   logic mem_we;
   logic [kscs_pkg::POS_W-1:0] mem_waddr;

   assign load_accept   = start & ~busy & (req_kind == kscs_pkg::KIND_LOAD);
   assign search_accept = start & ~busy & (req_kind == kscs_pkg::KIND_SEARCH);
   assign list_full     = (count_ff == kscs_pkg::CNT_W'(kscs_pkg::MAX_ENTRIES));

   // start_new restarts the list at entry 0; a full list drops the beat
   assign mem_we    = load_accept & (req_start_new | ~list_full);
   assign mem_waddr = req_start_new ? '0 : count_ff[kscs_pkg::POS_W-1:0];

   always_comb begin
      subset_size_in = subset_size_ff;
      cover_width_in = cover_width_ff;
      count_in       = count_ff;
      if (csr_we && csr_index == kscs_pkg::REG_SUBSET_SIZE) begin
         subset_size_in = csr_wdata;
      end
      if (csr_we && csr_index == kscs_pkg::REG_COVER_WIDTH) begin
         cover_width_in = csr_wdata;
      end
      if (load_accept) begin
         if (req_start_new) begin
            count_in = kscs_pkg::CNT_W'(1);
         end else if (!list_full) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         subset_size_ff <= kscs_pkg::REG_W'(1);
         cover_width_ff <= kscs_pkg::REG_W'(64);
         count_ff       <= '0;
      end else begin
         subset_size_ff <= subset_size_in;
         cover_width_ff <= cover_width_in;
         count_ff       <= count_in;
      end
   end

   // ------------------------------------------------------------------
   // Profile memory: one write port (loads), one registered read port (walk)
   // ------------------------------------------------------------------
   logic [kscs_pkg::COVER_BITS-1:0] profile_mem [kscs_pkg::MAX_ENTRIES];
   logic [kscs_pkg::COVER_BITS-1:0] rdata_ff;
   logic [kscs_pkg::POS_W-1:0]      rd_addr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         profile_mem[mem_waddr] <= req_profile_word[kscs_pkg::COVER_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= profile_mem[rd_addr];
   end

   // ------------------------------------------------------------------
   // Search setup: effective width, target bits, k
   // ------------------------------------------------------------------
   logic [kscs_pkg::REG_W-1:0]      w_calc;
   logic [kscs_pkg::REG_W-1:0]      k_sw;
   logic [kscs_pkg::REG_W-1:0]      k_all;
   logic [kscs_pkg::CNT_W-1:0]      k_calc;
   logic [kscs_pkg::COVER_BITS-1:0] target_calc;

   assign w_calc = (cover_width_ff > kscs_pkg::REG_W'(kscs_pkg::COVER_BITS)) ?
                   kscs_pkg::REG_W'(kscs_pkg::COVER_BITS) : cover_width_ff;
   assign k_sw   = (subset_size_ff < w_calc) ? subset_size_ff : w_calc;
   assign k_all  = (k_sw < kscs_pkg::REG_W'(count_ff)) ? k_sw : kscs_pkg::REG_W'(count_ff);
   assign k_calc = k_all[kscs_pkg::CNT_W-1:0];   // never above count_ff

   for (genvar gi = 0; gi < kscs_pkg::COVER_BITS; gi++) begin : g_target
      assign target_calc[gi] = (kscs_pkg::REG_W'(gi) < w_calc);
   end

   // ------------------------------------------------------------------
   // Slot stack: a row of cells, top of stack in cell 0, shifting on push/pop
   // ------------------------------------------------------------------
   kscs_pkg::stack_op_type stack_op;
   kscs_pkg::entry_type    push_entry;
   kscs_pkg::entry_type    stack_q [kscs_pkg::STACK_DEPTH];
   kscs_pkg::entry_type    stack_top;

   for (genvar gc = 0; gc < kscs_pkg::STACK_DEPTH; gc++) begin : g_cell
      kscs_pkg::entry_type up_entry;
      kscs_pkg::entry_type down_entry;
      if (gc == 0) begin : g_head
         assign up_entry = push_entry;
      end else begin : g_mid_up
         assign up_entry = stack_q[gc-1];
      end
      if (gc == kscs_pkg::STACK_DEPTH - 1) begin : g_tail
         assign down_entry = '0;
      end else begin : g_mid_down
         assign down_entry = stack_q[gc+1];
      end
      kscs_cell u_cell (
         .clock      (clock),
         .op         (stack_op),
         .up_entry   (up_entry),
         .down_entry (down_entry),
         .entry      (stack_q[gc])
      );
   end

   assign stack_top = stack_q[0];

   // ------------------------------------------------------------------
   // Walk control
   // ------------------------------------------------------------------
   state_type                       state_ff, state_in;
   logic [kscs_pkg::POS_W-1:0]      slot_ff, slot_in;      // slot being filled
   logic [kscs_pkg::POS_W-1:0]      cand_ff, cand_in;      // candidate position for it
   logic [kscs_pkg::CNT_W-1:0]      k_ff, k_in;
   logic [kscs_pkg::COVER_BITS-1:0] target_ff, target_in;
   logic [kscs_pkg::MAX_ENTRIES-1:0] mask_ff, mask_in;     // positions of stacked slots
   logic                            rsp_strobe_ff, rsp_strobe_in;
   logic                            rsp_found_ff, rsp_found_in;
   logic [kscs_pkg::MAX_ENTRIES-1:0] rsp_mask_ff, rsp_mask_in;

   logic [kscs_pkg::COVER_BITS-1:0]  new_cov;
   logic                             last_slot;
   logic                             hit;
   logic [kscs_pkg::CNT_W-1:0]       cand_next;
   logic [kscs_pkg::CNT_W-1:0]       back_next;
   logic [kscs_pkg::POS_W-1:0]       slot_dec;
   logic [kscs_pkg::MAX_ENTRIES-1:0] cand_onehot;
   logic [kscs_pkg::MAX_ENTRIES-1:0] top_onehot;

   // a position fits a slot if the slots after it still find room in the list
   function automatic logic fits(input logic [kscs_pkg::CNT_W-1:0] nc,
                                 input logic [kscs_pkg::POS_W-1:0] slot,
                                 input logic [kscs_pkg::CNT_W-1:0] k,
                                 input logic [kscs_pkg::CNT_W-1:0] n);
      return ((kscs_pkg::CNT_W+1)'(nc) + (kscs_pkg::CNT_W+1)'(k)) <=
             ((kscs_pkg::CNT_W+1)'(n) + (kscs_pkg::CNT_W+1)'(slot));
   endfunction

   assign new_cov   = ((slot_ff == '0) ? '0 : stack_top.cov) | rdata_ff;
   assign last_slot = (kscs_pkg::CNT_W'(slot_ff) + 1'b1) == k_ff;
   assign hit       = (new_cov & target_ff) == target_ff;
   assign cand_next = kscs_pkg::CNT_W'(cand_ff) + 1'b1;
   assign back_next = kscs_pkg::CNT_W'(stack_top.pos) + 1'b1;
   assign slot_dec  = slot_ff - 1'b1;

   for (genvar gm = 0; gm < kscs_pkg::MAX_ENTRIES; gm++) begin : g_onehot
      assign cand_onehot[gm] = (cand_ff == kscs_pkg::POS_W'(gm));
      assign top_onehot[gm]  = (stack_top.pos == kscs_pkg::POS_W'(gm));
   end

   always_comb begin
      state_in       = state_ff;
      slot_in        = slot_ff;
      cand_in        = cand_ff;
      k_in           = k_ff;
      target_in      = target_ff;
      mask_in        = mask_ff;
      rsp_strobe_in  = 1'b0;
      rsp_found_in   = rsp_found_ff;
      rsp_mask_in    = rsp_mask_ff;
      rd_addr        = cand_ff;
      stack_op       = '0;
      push_entry.pos = cand_ff;
      push_entry.cov = new_cov;
      case (state_ff)
         ST_IDLE: begin
            if (search_accept) begin
               k_in      = k_calc;
               target_in = target_calc;
               mask_in   = '0;
               slot_in   = '0;
               cand_in   = '0;
               rd_addr   = '0;
               if (k_calc == '0) begin
                  // nothing to choose: answer at once
                  rsp_strobe_in = 1'b1;
                  rsp_found_in  = 1'b0;
                  rsp_mask_in   = '0;
               end else begin
                  state_in = ST_PLACE;
               end
            end
         end
         ST_PLACE: begin
            if (last_slot) begin
               if (hit) begin
                  rsp_strobe_in = 1'b1;
                  rsp_found_in  = 1'b1;
                  rsp_mask_in   = mask_ff | cand_onehot;
                  state_in      = ST_IDLE;
               end else if (fits(cand_next, slot_ff, k_ff, count_ff)) begin
                  // last slot advances first
                  cand_in = cand_next[kscs_pkg::POS_W-1:0];
                  rd_addr = cand_next[kscs_pkg::POS_W-1:0];
               end else begin
                  state_in = ST_BACK;
               end
            end else begin
               // descend: stack this slot, next slot starts right after it
               stack_op.push = 1'b1;
               mask_in       = mask_ff | cand_onehot;
               slot_in       = slot_ff + 1'b1;
               cand_in       = cand_next[kscs_pkg::POS_W-1:0];
               rd_addr       = cand_next[kscs_pkg::POS_W-1:0];
            end
         end
         ST_BACK: begin
            if (slot_ff == '0) begin
               // every subset visited
               rsp_strobe_in = 1'b1;
               rsp_found_in  = 1'b0;
               rsp_mask_in   = '0;
               state_in      = ST_IDLE;
            end else begin
               stack_op.pop = 1'b1;
               mask_in      = mask_ff & ~top_onehot;
               slot_in      = slot_dec;
               if (fits(back_next, slot_dec, k_ff, count_ff)) begin
                  cand_in  = back_next[kscs_pkg::POS_W-1:0];
                  rd_addr  = back_next[kscs_pkg::POS_W-1:0];
                  state_in = ST_PLACE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         slot_ff       <= slot_in;
         cand_ff       <= cand_in;
         k_ff          <= k_in;
         target_ff     <= target_in;
         mask_ff       <= mask_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_mask_ff   <= rsp_mask_in;
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_chosen_mask = kscs_pkg::PROFILE_W'(rsp_mask_ff);

endmodule

@@ rtl/kscs_checker.sv @@
// kscs_checker: port-level checks of k_subset_cover_search over time, bound to the top level.
// Depends on kscs_pkg and k_subset_cover_search.
module kscs_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              req_kind,
   input logic                              req_start_new,
   input logic [kscs_pkg::PROFILE_W-1:0]    req_profile_word,
   input logic                              rsp_strobe,
   input logic                              rsp_found,
   input logic [kscs_pkg::PROFILE_W-1:0]    rsp_chosen_mask,
   input logic                              csr_we,
   input logic [kscs_pkg::CSR_IDX_W-1:0]    csr_index,
   input logic [kscs_pkg::REG_W-1:0]        csr_wdata
);

   // a load beat never starts a walk and never yields a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == kscs_pkg::KIND_LOAD) |=> (!busy && !rsp_strobe))
      else $error("load beat raised busy or a result");

   // a search beat either answers at once or starts walking, never both
   a_search_starts: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == kscs_pkg::KIND_SEARCH) |=> (busy ^ rsp_strobe))
      else $error("search beat neither answered nor started a walk");

   // a walk ends only with its result
   a_end_with_result: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_strobe)
      else $error("walk ended without a result beat");

   // a result follows a search beat or a walk
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) ||
                      $past(start && !busy && req_kind == kscs_pkg::KIND_SEARCH)))
      else $error("result beat without a search");

   // found selects something; not found selects nothing
   a_mask_matches_found: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_found ? (rsp_chosen_mask != '0) : (rsp_chosen_mask == '0)))
      else $error("chosen mask disagrees with found");

endmodule

bind k_subset_cover_search kscs_checker u_kscs_checker (.*);

@@ test/tb_k_subset_cover_search.sv @@
// tb_k_subset_cover_search: self-checking bench for the k-subset cover search block.
// Depends on rtl/kscs_pkg.sv (sizes, register indexes, beat kinds) and the DUT top level.
// Predicts each search by its own lexicographic k-subset walk and scores every result strobe.
module tb_k_subset_cover_search;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int W        = kscs_pkg::PROFILE_W;
   localparam int IDX_W    = kscs_pkg::CSR_IDX_W;
   localparam int MAX_LIST = kscs_pkg::MAX_ENTRIES;
   localparam int COV_BITS = kscs_pkg::COVER_BITS;

   // indexes past the two real registers; writes there must be dropped
   localparam logic [IDX_W-1:0] REG_SPARE_2 = IDX_W'(2);
   localparam logic [IDX_W-1:0] REG_SPARE_3 = IDX_W'(3);

   localparam int LIST_CAP      = 9;    // random lists stay short so every walk stays short
   localparam int IDLE_PCT      = 34;   // sender idles in about this share of cycles
   localparam int SETTLE_CYCLES = 2;    // a load never raises busy, so a short pause will do
   localparam int DRAIN_CYCLES  = 40;   // watch for stray strobes after the last result
   localparam int RANDOM_ITEMS  = 300;
   localparam longint TIMEOUT_NS = 64'd10_000_000;

   // expected result of one search beat
   typedef struct packed {
      logic         found;
      logic [W-1:0] mask;
   } cover_type;

   // ---------------------------------------------------------------------------------------
   // DUT hookup; every input has a known value from time zero
   // ---------------------------------------------------------------------------------------
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic              req_kind = kscs_pkg::KIND_LOAD;
   logic              req_start_new = 1'b0;
   logic [W-1:0]      req_profile_word = '0;
   logic              rsp_strobe;
   logic              rsp_found;
   logic [W-1:0]      rsp_chosen_mask;
   logic              csr_we = 1'b0;
   logic [IDX_W-1:0]  csr_index = '0;
   logic [kscs_pkg::REG_W-1:0] csr_wdata = '0;

   k_subset_cover_search dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_start_new    (req_start_new),
      .req_profile_word (req_profile_word),
      .rsp_strobe       (rsp_strobe),
      .rsp_found        (rsp_found),
      .rsp_chosen_mask  (rsp_chosen_mask),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // Shadow of the block: profile list, its length and both registers
   // ---------------------------------------------------------------------------------------
   logic [W-1:0] profile_mem [MAX_LIST];
   int           list_len   = 0;
   int           cfg_subset = 1;
   int           cfg_width  = 64;

   cover_type expected_covers [$];   // one entry per accepted search, oldest first

   bit no_idle   = 1'b0;          // set for the stretch with back-to-back beats
   int n_items    = 0;
   int n_loads    = 0;
   int n_searches = 0;
   int n_found    = 0;
   int n_writes   = 0;
   int n_checked  = 0;
   int n_bad      = 0;

   // First subset in lexicographic order of positions whose OR covers the low bits.
   // Depth-first walk with an explicit stack; a branch is cut when even every remaining
   // entry ORed in could not finish the cover, which never skips the first hit.
   function automatic cover_type find_first_cover();
      cover_type    res;
      int           w, k, t, j, i;
      bit           done;
      int           pick [MAX_LIST];
      logic [W-1:0] target;
      logic [W-1:0] acc  [MAX_LIST+1];
      logic [W-1:0] tail [MAX_LIST+1];
      res    = '0;
      w      = (cfg_width > COV_BITS) ? COV_BITS : cfg_width;
      target = (w >= W) ? {W{1'b1}} : ((W'(1) << w) - W'(1));
      k      = cfg_subset;
      if (k > w) k = w;
      if (k > list_len) k = list_len;
      done = (k == 0);   // empty subset never counts as found
      tail[list_len] = '0;
      for (i = list_len; i > 0; i--) tail[i-1] = tail[i] | profile_mem[i-1];
      acc[0] = '0;
      t = 0;
      j = 0;
      while (!done) begin
         if (j + (k - t) <= list_len && ((acc[t] | tail[j]) & target) == target) begin
            pick[t]  = j;
            acc[t+1] = acc[t] | profile_mem[j];
            if (t + 1 == k) begin
               if ((acc[t+1] & target) == target) begin
                  res.found = 1'b1;
                  for (i = 0; i < k; i++) res.mask[pick[i]] = 1'b1;
                  done = 1'b1;
               end else begin
                  j = j + 1;
               end
            end else begin
               t = t + 1;
               j = j + 1;
            end
         end else if (t == 0) begin
            done = 1'b1;   // walk exhausted: no cover, mask stays zero
         end else begin
            t = t - 1;
            j = pick[t] + 1;
         end
      end
      return res;
   endfunction

   // Mix of dense, sparse, contiguous-run and all-or-nothing words so that covers
   // are sometimes found early, sometimes late and sometimes not at all.
   function automatic logic [W-1:0] rand_profile();
      logic [W-1:0] a, b, c, res;
      int           lo, span;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      c = {$urandom, $urandom};
      case ($urandom_range(4))
         0: res = a;
         1: res = a | b | c;
         2: res = a & b;
         3: begin
            lo   = $urandom_range(0, W - 1);
            span = $urandom_range(1, W - lo);
            res  = ({W{1'b1}} >> (W - span)) << lo;
         end
         default: res = ($urandom_range(3) == 0) ? {W{1'b1}} : {W{1'b0}};
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Beat driver. Start is only ever raised here and lowered in gaps, never both in one step.
   // ---------------------------------------------------------------------------------------
   task automatic send_beat(input logic kind, input logic fresh, input logic [W-1:0] word);
      cover_type exp_cover;
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_kind         <= kind;
      req_start_new    <= fresh;
      req_profile_word <= word;
      // accepted at the first edge that sees busy low
      do @(posedge clock); while (busy);
      n_items++;
      if (kind == kscs_pkg::KIND_LOAD) begin
         n_loads++;
         if (fresh) list_len = 0;
         // a full list drops the word
         if (list_len < MAX_LIST) begin
            profile_mem[list_len] = word;
            list_len++;
         end
      end else begin
         exp_cover = find_first_cover();
         expected_covers = {expected_covers, exp_cover};
         n_searches++;
         if (exp_cover.found) n_found++;
      end
   endtask

   // Lower start and wait until every search has answered and the block is idle.
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (expected_covers.size() != 0 || busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; only called after settle().
   task automatic write_reg(input logic [IDX_W-1:0] idx, input int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= kscs_pkg::REG_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      n_writes++;
      case (idx)
         kscs_pkg::REG_SUBSET_SIZE: cfg_subset = value & 8'h7F;
         kscs_pkg::REG_COVER_WIDTH: cfg_width  = value & 8'h7F;
         default: ;   // unknown index: no effect
      endcase
   endtask

   // ---------------------------------------------------------------------------------------
   // Result checker: the strobe cannot be held off, so every strobe is scored as it comes
   // ---------------------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [W-1:0] exp_v,
                                  input logic [W-1:0] act_v);
      n_bad++;
      if (n_bad <= 10)
         $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, exp_v, act_v);
   endtask

   always @(posedge clock) begin
      cover_type want;
      if (!reset && rsp_strobe) begin
         if (expected_covers.size() == 0) begin
            report_mismatch("result with no search pending", '0, rsp_chosen_mask);
         end else begin
            want = expected_covers.pop_front();
            n_checked++;
            if (rsp_found !== want.found)
               report_mismatch("found", W'(want.found), W'(rsp_found));
            if (rsp_chosen_mask !== want.mask)
               report_mismatch("chosen_mask", want.mask, rsp_chosen_mask);
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Directed tests
   // ---------------------------------------------------------------------------------------

   // Reset config is subset 1, cover 64, empty list.
   task automatic test_reset_values();
      send_beat(kscs_pkg::KIND_SEARCH, 1'b0, '0);                  // empty list: not found
      send_beat(kscs_pkg::KIND_LOAD,   1'b0, '0);
      send_beat(kscs_pkg::KIND_LOAD,   1'b0, {W{1'b1}});
      send_beat(kscs_pkg::KIND_SEARCH, 1'b0, '0);                  // entry 1 alone covers
      send_beat(kscs_pkg::KIND_LOAD,   1'b1, 64'hFFFF_FFFF_FFFF_FFFE);
      send_beat(kscs_pkg::KIND_SEARCH, 1'b0, '0);                  // bit 0 missing: no cover
   endtask

   // k forced to zero by subset size or by cover width.
   task automatic test_empty_subset();
      settle();
      write_reg(kscs_pkg::REG_SUBSET_SIZE, 0);
      send_beat(kscs_pkg::KIND_SEARCH, 1'b0, '0);
      settle();
      write_reg(kscs_pkg::REG_SUBSET_SIZE, 2);
      write_reg(kscs_pkg::REG_COVER_WIDTH, 0);
      send_beat(kscs_pkg::KIND_SEARCH, 1'b0, '0);
   endtask

   // Register extremes, cover width beyond the stored bits, alternating bit patterns.
   task automatic test_wide_cover();
      settle();
      write_reg(kscs_pkg::REG_SUBSET_SIZE, 127);
      write_reg(kscs_pkg::REG_COVER_WIDTH, 127);
      send_beat(kscs_pkg::KIND_LOAD,   1'b1, 64'hFFFF_FFFF_0000_0000);
      send_beat(kscs_pkg::KIND_LOAD,   1'b0, 64'h0000_0000_FFFF_FFFF);
      send_beat(kscs_pkg::KIND_LOAD,   1'b0, '0);
      send_beat(kscs_pkg::KIND_SEARCH, 1'b0, '0);                  // k = 3, all entries
      settle();
      write_reg(kscs_pkg::REG_SUBSET_SIZE, 2);
      write_reg(kscs_pkg::REG_COVER_WIDTH, 100);
      send_beat(kscs_pkg::KIND_SEARCH, 1'b0, '0);                  // first pair covers
      settle();
      write_reg(kscs_pkg::REG_SUBSET_SIZE, 127);
      write_reg(kscs_pkg::REG_COVER_WIDTH, 1);
      send_beat(kscs_pkg::KIND_LOAD,   1'b1, 64'hAAAA_AAAA_AAAA_AAAA);
      send_beat(kscs_pkg::KIND_LOAD,   1'b0, 64'h5555_5555_5555_5555);
      send_beat(kscs_pkg::KIND_SEARCH, 1'b0, '0);                  // k = 1, bit 0 only
      settle();
      write_reg(kscs_pkg::REG_SUBSET_SIZE, 64);
      write_reg(kscs_pkg::REG_COVER_WIDTH, 64);
      send_beat(kscs_pkg::KIND_SEARCH, 1'b0, '0);                  // k clipped to list length
   endtask

   // A search beat must ignore start_new and the profile word.
   task automatic test_ignored_fields();
      settle();
      write_reg(kscs_pkg::REG_SUBSET_SIZE, 1);
      send_beat(kscs_pkg::KIND_LOAD,   1'b1, {W{1'b1}});
      send_beat(kscs_pkg::KIND_SEARCH, 1'b1, '0);
      send_beat(kscs_pkg::KIND_SEARCH, 1'b0, {$urandom, $urandom});
   endtask

   // Writes past the last register leave both registers alone.
   task automatic test_unknown_register();
      settle();
      write_reg(kscs_pkg::REG_SUBSET_SIZE, 2);
      write_reg(kscs_pkg::REG_COVER_WIDTH, 2);
      write_reg(REG_SPARE_2, 1);   // would make a single entry look enough
      write_reg(REG_SPARE_3, 0);   // would force k = 0
      send_beat(kscs_pkg::KIND_LOAD,   1'b1, 64'h1);
      send_beat(kscs_pkg::KIND_LOAD,   1'b0, 64'h2);
      send_beat(kscs_pkg::KIND_SEARCH, 1'b0, '0);                  // needs both entries
   endtask

   // Fill all 64 slots, push two more that must be dropped, then search with k of 1, 2, 64.
   task automatic test_full_list();
      int i;
      settle();
      write_reg(kscs_pkg::REG_SUBSET_SIZE, 1);
      write_reg(kscs_pkg::REG_COVER_WIDTH, 64);
      for (i = 0; i < MAX_LIST - 1; i++)
         send_beat(kscs_pkg::KIND_LOAD, i == 0, rand_profile() & ~(W'(1) << i));
      send_beat(kscs_pkg::KIND_LOAD, 1'b0, {W{1'b1}});            // only the last slot covers
      send_beat(kscs_pkg::KIND_LOAD, 1'b0, '0);
      send_beat(kscs_pkg::KIND_LOAD, 1'b0, '0);
      send_beat(kscs_pkg::KIND_SEARCH, 1'b0, '0);
      settle();
      write_reg(kscs_pkg::REG_SUBSET_SIZE, 2);
      send_beat(kscs_pkg::KIND_SEARCH, 1'b0, '0);
      settle();
      write_reg(kscs_pkg::REG_SUBSET_SIZE, 64);
      write_reg(kscs_pkg::REG_COVER_WIDTH, 127);
      send_beat(kscs_pkg::KIND_SEARCH, 1'b0, '0);                  // every entry chosen
   endtask

   // ---------------------------------------------------------------------------------------
   // Random phases: a fresh config each phase, then mostly well-formed list builds followed
   // by searches, with stray loads and early searches mixed in. Lists never exceed LIST_CAP.
   // ---------------------------------------------------------------------------------------
   task automatic test_random_searches(input int count);
      int stop_at, phase, phase_len, in_phase, m, s, i, r, subset, width;
      stop_at = n_items + count;
      phase   = 0;
      while (n_items < stop_at) begin
         settle();
         r = $urandom_range(99);
         if (r < 8)       subset = $urandom_range(1) ? 0 : 127;
         else if (r < 14) subset = 64;
         else             subset = $urandom_range(1, 5);
         r = $urandom_range(99);
         if (r < 6)       width = 0;
         else if (r < 14) width = $urandom_range(65, 127);
         else if (r < 30) width = 64;
         else if (r < 60) width = $urandom_range(1, 63);
         else             width = $urandom_range(1, 10);
         if ($urandom_range(9) == 0)
            write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, $urandom_range(127));
         write_reg(kscs_pkg::REG_SUBSET_SIZE, subset);
         write_reg(kscs_pkg::REG_COVER_WIDTH, width);
         no_idle   = (phase == 2);
         phase_len = $urandom_range(20, 45);
         in_phase  = 0;
         // open every phase with a fresh list so the directed 64-entry list never lingers
         send_beat(kscs_pkg::KIND_LOAD, 1'b1, rand_profile());
         while (in_phase < phase_len) begin
            if ($urandom_range(99) < 75) begin
               m = $urandom_range(1, LIST_CAP);
               for (i = 0; i < m; i++)
                  send_beat(kscs_pkg::KIND_LOAD, i == 0, rand_profile());
               s = $urandom_range(1, 3);
               for (i = 0; i < s; i++)
                  send_beat(kscs_pkg::KIND_SEARCH, 1'($urandom_range(1)), {$urandom, $urandom});
               in_phase += m + s;
            end else begin
               if ($urandom_range(1))
                  send_beat(kscs_pkg::KIND_LOAD,
                            (list_len >= LIST_CAP) ? 1'b1 : 1'($urandom_range(1)),
                            rand_profile());
               else
                  send_beat(kscs_pkg::KIND_SEARCH, 1'($urandom_range(1)), {$urandom, $urandom});
               in_phase++;
            end
         end
         phase++;
      end
      no_idle = 1'b0;
   endtask

   // ---------------------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_empty_subset();
      test_wide_cover();
      test_ignored_fields();
      test_unknown_register();
      test_full_list();
      test_random_searches(RANDOM_ITEMS);
      // drain: everything answered, then watch a while for stray strobes
      start <= 1'b0;
      @(posedge clock);
      while (expected_covers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d beats: %0d profile loads, %0d searches (%0d with a cover found).",
               n_items, n_loads, n_searches, n_found);
      $display("Scored %0d result strobes across %0d register writes; %0d mismatches.",
               n_checked, n_writes, n_bad);
      if (n_bad == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // hang guard
   initial begin
      #(TIMEOUT_NS);
      $display("Timeout with %0d searches still unanswered", expected_covers.size());
      $display("Some tests failed");
      $finish;
   end

endmodule

@@ files.f @@
rtl/kscs_pkg.sv
rtl/kscs_cell.sv
rtl/k_subset_cover_search.sv
rtl/kscs_checker.sv
test/tb_k_subset_cover_search.sv
